// ===== design/int_arith_overflow_to_real_macros.svh =====
// Assertion helpers used by the RTL files.
`ifndef INT_ARITH_OVERFLOW_TO_REAL_MACROS_SVH
`define INT_ARITH_OVERFLOW_TO_REAL_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define IAOTR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define IAOTR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/iaotr_pkg.sv =====
`default_nettype none

package iaotr_pkg;

    // Operation codes of a request.
    localparam logic [2:0] OP_ADD  = 3'd0;
    localparam logic [2:0] OP_SUB  = 3'd1;
    localparam logic [2:0] OP_MUL  = 3'd2;
    localparam logic [2:0] OP_IDIV = 3'd3;
    localparam logic [2:0] OP_MOD  = 3'd4;
    localparam logic [2:0] OP_ABS  = 3'd5;
    localparam logic [2:0] OP_NEG  = 3'd6;
    localparam logic [2:0] OP_ID   = 3'd7;

    // Result status codes.
    localparam logic [1:0] ST_INT   = 2'd0;
    localparam logic [1:0] ST_REAL  = 2'd1;
    localparam logic [1:0] ST_UNDEF = 2'd2;

    // IEEE single exponent bias.
    localparam int EXP_BIAS = 127;

    typedef struct packed {
        logic [2:0]         req_type;
        logic signed [31:0] operand_a;
        logic signed [31:0] operand_b;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] int_value;
        logic [31:0]        real_bits;
    } rsp_t;

    // Control that rides along the divider stages.
    typedef struct packed {
        logic valid;
        logic is_div;
        logic is_mod;
        logic undef;
        logic qneg;
        logic rneg;
    } div_tag_t;

endpackage

`default_nettype wire

// ===== design/int_arith_overflow_to_real.sv =====
// Integer arithmetic unit with promotion to real on overflow.
//
// Request channel (req_valid, req_stall, req): op code and two signed
// operands. Response channel (rsp_valid, rsp_stall, rsp): status, integer
// value and IEEE single bits. Each request gives exactly one response, in
// order. Only the low WORD_BITS bits of each operand are used.
//
// The pipeline length is set by the restoring divider, which resolves one
// quotient bit per stage. All other operations travel through a delay line
// of matching length. One request is taken per cycle while the response
// side keeps up.
//
// Reset clears all valid bits; the pipeline comes up empty.
// When the receiver stalls a waiting response, the whole pipeline holds and
// req_stall is raised; nothing is lost or repeated, and req_stall falls in
// the same cycle as rsp_stall.
`default_nettype none

`include "int_arith_overflow_to_real_macros.svh"

module int_arith_overflow_to_real #(
    parameter int WORD_BITS = 32
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            req_valid,
    output logic                 req_stall,
    input  wire iaotr_pkg::req_t req,
    output logic                 rsp_valid,
    input  wire logic            rsp_stall,
    output iaotr_pkg::rsp_t      rsp
);

    localparam int W    = WORD_BITS;
    localparam int P    = 2 * W;
    localparam int NDLY = W - 4;
    localparam logic [7:0] EXP_MIN = 8'(iaotr_pkg::EXP_BIAS + W - 1);

    logic en;
    logic rsp_valid_reg;
    iaotr_pkg::rsp_t rsp_reg;

    // The pipeline advances unless a finished response is held.
    assign en        = !(rsp_valid_reg && rsp_stall);
    assign req_stall = !en;

    // Stage 1: capture the request.
    logic         s1_valid_reg;
    logic [2:0]   s1_op_reg;
    logic [W-1:0] s1_a_reg;
    logic [W-1:0] s1_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_op_reg <= req.req_type;
            s1_a_reg  <= req.operand_a[W-1:0];
            s1_b_reg  <= req.operand_b[W-1:0];
        end
    end

    // Stage 2: exact wide result, and divider set-up.
    logic signed [P-1:0] ax;
    logic signed [P-1:0] bx;
    logic signed [P-1:0] prod;
    logic signed [P-1:0] s2_r_next;
    logic signed [P-1:0] s2_r_reg;
    logic [W-1:0]        a_mag;
    logic [W-1:0]        b_mag;
    iaotr_pkg::div_tag_t tag_next;

    assign ax    = P'($signed(s1_a_reg));
    assign bx    = P'($signed(s1_b_reg));
    assign prod  = ax * bx;
    assign a_mag = s1_a_reg[W-1] ? (~s1_a_reg + 1'b1) : s1_a_reg;
    assign b_mag = s1_b_reg[W-1] ? (~s1_b_reg + 1'b1) : s1_b_reg;

    always_comb
    begin
        unique case (s1_op_reg)
            iaotr_pkg::OP_ADD: s2_r_next = ax + bx;
            iaotr_pkg::OP_SUB: s2_r_next = ax - bx;
            iaotr_pkg::OP_MUL: s2_r_next = prod;
            iaotr_pkg::OP_ABS: s2_r_next = ax[P-1] ? -ax : ax;
            iaotr_pkg::OP_NEG: s2_r_next = -ax;
            iaotr_pkg::OP_ID:  s2_r_next = ax;
            default:           s2_r_next = '0;
        endcase
    end

    always_comb
    begin
        tag_next.valid  = s1_valid_reg;
        tag_next.is_div = (s1_op_reg == iaotr_pkg::OP_IDIV);
        tag_next.is_mod = (s1_op_reg == iaotr_pkg::OP_MOD);
        tag_next.undef  = ((tag_next.is_div || tag_next.is_mod) && (s1_b_reg == '0))
                       || (tag_next.is_div && (s1_a_reg == {1'b1, {(W-1){1'b0}}})
                           && (s1_b_reg == '1));
        tag_next.qneg   = s1_a_reg[W-1] ^ s1_b_reg[W-1];
        tag_next.rneg   = s1_a_reg[W-1];
    end

    iaotr_pkg::div_tag_t s2_tag_reg;
    logic [W-1:0]        s2_dvd_reg;
    logic [W-1:0]        s2_dvs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_tag_reg <= '0;
        end
        else if (en)
        begin
            s2_tag_reg <= tag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_r_reg   <= s2_r_next;
            s2_dvd_reg <= a_mag;
            s2_dvs_reg <= b_mag;
        end
    end

    // Stage 3: overflow test, integer value and magnitude for conversion.
    logic            ovf;
    iaotr_pkg::rsp_t s3_next;
    iaotr_pkg::rsp_t s3_reg;
    logic            s3_sign_reg;
    logic [P-1:0]    s3_mag_reg;

    assign ovf = (s2_r_reg[P-1:W-1] != {(P-W+1){s2_r_reg[W-1]}});

    always_comb
    begin
        s3_next.status    = ovf ? iaotr_pkg::ST_REAL : iaotr_pkg::ST_INT;
        s3_next.int_value = ovf ? '0 : 32'($signed(s2_r_reg[W-1:0]));
        s3_next.real_bits = '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_reg      <= s3_next;
            s3_sign_reg <= s2_r_reg[P-1];
            s3_mag_reg  <= s2_r_reg[P-1] ? (~s2_r_reg + 1'b1) : s2_r_reg;
        end
    end

    // Conversion to single for promoted results.
    iaotr_pkg::rsp_t cvt_out;

    iaotr_cvt #(
        .MAG_W (P)
    ) u_cvt (
        .clk      (clk),
        .en       (en),
        .pass_in  (s3_reg),
        .sign_in  (s3_sign_reg),
        .mag_in   (s3_mag_reg),
        .pass_out (cvt_out)
    );

    // Divider for idiv and mod.
    iaotr_pkg::div_tag_t div_tag;
    logic [W-1:0]        div_quot;
    logic [W-1:0]        div_rem;

    iaotr_div #(
        .W (W)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .tag_in  (s2_tag_reg),
        .dvd_in  (s2_dvd_reg),
        .dvs_in  (s2_dvs_reg),
        .tag_out (div_tag),
        .quot    (div_quot),
        .rem     (div_rem)
    );

    // Delay line that lines the other results up with the divider.
    iaotr_pkg::rsp_t dl_reg [NDLY];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dl_reg[0] <= cvt_out;
            for (int k = 1; k < NDLY; k++)
            begin
                dl_reg[k] <= dl_reg[k-1];
            end
        end
    end

    // Final stage: pick the divider or the delayed result.
    logic [W-1:0]    q_s;
    logic [W-1:0]    r_s;
    iaotr_pkg::rsp_t rsp_next;

    assign q_s = div_tag.qneg ? (~div_quot + 1'b1) : div_quot;
    assign r_s = div_tag.rneg ? (~div_rem + 1'b1) : div_rem;

    always_comb
    begin
        if (div_tag.is_div || div_tag.is_mod)
        begin
            rsp_next.real_bits = '0;
            if (div_tag.undef)
            begin
                rsp_next.status    = iaotr_pkg::ST_UNDEF;
                rsp_next.int_value = '0;
            end
            else
            begin
                rsp_next.status    = iaotr_pkg::ST_INT;
                rsp_next.int_value = div_tag.is_div ? 32'($signed(q_s))
                                                    : 32'($signed(r_s));
            end
        end
        else
        begin
            rsp_next = dl_reg[NDLY-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            rsp_valid_reg <= div_tag.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Fields that do not belong to the status are zero, and a promoted
    // result is at least as large as the word range.
    logic out_int;
    logic out_real;

    assign out_int  = rsp_valid && (rsp.status == iaotr_pkg::ST_INT);
    assign out_real = rsp_valid && (rsp.status == iaotr_pkg::ST_REAL);

    `IAOTR_ASSERT_IMP(a_int_zero, rsp_valid && !out_int, rsp.int_value == '0, "int_value set")
    `IAOTR_ASSERT_IMP(a_real_zero, rsp_valid && !out_real, rsp.real_bits == '0, "real_bits set")
    `IAOTR_ASSERT_IMP(a_real_range, out_real, rsp.real_bits[30:23] >= EXP_MIN, "real too small")

endmodule

`default_nettype wire

// ===== design/iaotr_div.sv =====
`default_nettype none

// Restoring divider on unsigned magnitudes, one quotient bit per stage.
module iaotr_div #(
    parameter int W = 32
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                en,
    input  wire iaotr_pkg::div_tag_t tag_in,
    input  wire logic [W-1:0]        dvd_in,
    input  wire logic [W-1:0]        dvs_in,
    output iaotr_pkg::div_tag_t      tag_out,
    output logic [W-1:0]             quot,
    output logic [W-1:0]             rem
);

    iaotr_pkg::div_tag_t tag_reg [W];
    logic [W-1:0] rem_reg [W];
    logic [W-1:0] dvd_reg [W];
    logic [W-1:0] dvs_reg [W];
    logic [W-1:0] quo_reg [W];

    iaotr_pkg::div_tag_t tag_prev [W];
    logic [W-1:0] rem_prev [W];
    logic [W-1:0] dvd_prev [W];
    logic [W-1:0] dvs_prev [W];
    logic [W-1:0] quo_prev [W];

    genvar i;
    generate
        for (i = 0; i < W; i++) begin : g_stage
            logic [W:0] trial;

            // Stage inputs come from the ports or the stage before.
            if (i == 0) begin : g_first
                assign tag_prev[i] = tag_in;
                assign rem_prev[i] = '0;
                assign dvd_prev[i] = dvd_in;
                assign dvs_prev[i] = dvs_in;
                assign quo_prev[i] = '0;
            end else begin : g_next
                assign tag_prev[i] = tag_reg[i-1];
                assign rem_prev[i] = rem_reg[i-1];
                assign dvd_prev[i] = dvd_reg[i-1];
                assign dvs_prev[i] = dvs_reg[i-1];
                assign quo_prev[i] = quo_reg[i-1];
            end

            // Bring down one dividend bit and try the subtraction.
            assign trial = {rem_prev[i], dvd_prev[i][W-1]} - {1'b0, dvs_prev[i]};

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    tag_reg[i] <= '0;
                end
                else if (en)
                begin
                    tag_reg[i] <= tag_prev[i];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (!trial[W])
                    begin
                        rem_reg[i] <= trial[W-1:0];
                    end
                    else
                    begin
                        rem_reg[i] <= {rem_prev[i][W-2:0], dvd_prev[i][W-1]};
                    end
                    quo_reg[i] <= {quo_prev[i][W-2:0], ~trial[W]};
                    dvd_reg[i] <= {dvd_prev[i][W-2:0], 1'b0};
                    dvs_reg[i] <= dvs_prev[i];
                end
            end
        end
    endgenerate

    assign tag_out = tag_reg[W-1];
    assign quot    = quo_reg[W-1];
    assign rem     = rem_reg[W-1];

endmodule

`default_nettype wire

// ===== design/iaotr_cvt.sv =====
`default_nettype none

// Integer magnitude to IEEE single, three stages: coarse normalize,
// fine normalize, round and pack. The integer part of the result rides along.
module iaotr_cvt #(
    parameter int MAG_W = 64
) (
    input  wire logic            clk,
    input  wire logic            en,
    input  wire iaotr_pkg::rsp_t pass_in,
    input  wire logic            sign_in,
    input  wire logic [MAG_W-1:0] mag_in,
    output iaotr_pkg::rsp_t      pass_out
);

    localparam int LZ_W  = $clog2(MAG_W);
    localparam int SPLIT = LZ_W / 2;
    localparam logic [7:0] EXP_TOP = 8'(MAG_W - 1 + iaotr_pkg::EXP_BIAS);

    iaotr_pkg::rsp_t  p1_reg, p2_reg, p3_reg;
    logic             s1_reg, s2_reg;
    logic [MAG_W-1:0] n1_reg, n2_reg;
    logic [LZ_W-1:0]  lz1_reg, lz2_reg;

    logic [MAG_W-1:0] n1_next, n2_next;
    logic [LZ_W-1:0]  lz1_next, lz2_next;

    // Coarse normalize: the larger shift steps.
    always_comb
    begin
        n1_next  = mag_in;
        lz1_next = '0;
        for (int k = LZ_W - 1; k >= SPLIT; k--)
        begin
            if ((n1_next >> (MAG_W - (1 << k))) == '0)
            begin
                n1_next     = n1_next << (1 << k);
                lz1_next[k] = 1'b1;
            end
        end
    end

    // Fine normalize: the remaining shift steps.
    always_comb
    begin
        n2_next  = n1_reg;
        lz2_next = lz1_reg;
        for (int k = SPLIT - 1; k >= 0; k--)
        begin
            if ((n2_next >> (MAG_W - (1 << k))) == '0)
            begin
                n2_next     = n2_next << (1 << k);
                lz2_next[k] = 1'b1;
            end
        end
    end

    // Round to nearest even and pack.
    logic [23:0] mant;
    logic        half;
    logic        sticky;
    logic        up;
    logic [24:0] mant_rnd;
    logic [7:0]  exp_b;
    iaotr_pkg::rsp_t p3_next;

    always_comb
    begin
        mant     = n2_reg[MAG_W-1 -: 24];
        half     = n2_reg[MAG_W-25];
        sticky   = |n2_reg[MAG_W-26:0];
        up       = half & (sticky | mant[0]);
        mant_rnd = {1'b0, mant} + {24'd0, up};
        exp_b    = EXP_TOP - 8'(lz2_reg) + {7'd0, mant_rnd[24]};
        p3_next  = p2_reg;
        if (p2_reg.status == iaotr_pkg::ST_REAL)
        begin
            p3_next.real_bits = {s2_reg, exp_b, mant_rnd[22:0]};
        end
        else
        begin
            p3_next.real_bits = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg  <= pass_in;
            s1_reg  <= sign_in;
            n1_reg  <= n1_next;
            lz1_reg <= lz1_next;
            p2_reg  <= p1_reg;
            s2_reg  <= s1_reg;
            n2_reg  <= n2_next;
            lz2_reg <= lz2_next;
            p3_reg  <= p3_next;
        end
    end

    assign pass_out = p3_reg;

endmodule

`default_nettype wire
